/* rtl/pctcp_pkg.sv */
// Shared types and constants for the point to triangle closest point block.
`default_nettype none

package pctcp_pkg;

  // Region of the triangle that holds the closest point.
  typedef enum logic [2:0] {
    REGION_VERT_A  = 3'd0,
    REGION_VERT_B  = 3'd1,
    REGION_EDGE_AB = 3'd2,
    REGION_VERT_C  = 3'd3,
    REGION_EDGE_AC = 3'd4,
    REGION_EDGE_BC = 3'd5,
    REGION_FACE    = 3'd6
  } region_e;

  // Width of one limb in the split wide multipliers.
  localparam int MUL_LIMB = 26;

endpackage

`default_nettype wire

/* rtl/point_triangle_closest_point_top.sv */
// Throughput: one word per cycle unless back-pressure stalls the pipeline; the
// chain is set by the one-bit-per-stage rounded divider in the back part,
// COORD_BITS + 3 stages deep.
// Reset: rst_ni clears all valid bits and queue pointers; no clearing pass.
// Top level: front classifier, decoupling queue, back divider and output queue.
`default_nettype none

module point_triangle_closest_point_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [COORD_BITS-1:0] vert_a_x_i,
  input  logic signed [COORD_BITS-1:0] vert_a_y_i,
  input  logic signed [COORD_BITS-1:0] vert_a_z_i,
  input  logic signed [COORD_BITS-1:0] vert_b_x_i,
  input  logic signed [COORD_BITS-1:0] vert_b_y_i,
  input  logic signed [COORD_BITS-1:0] vert_b_z_i,
  input  logic signed [COORD_BITS-1:0] vert_c_x_i,
  input  logic signed [COORD_BITS-1:0] vert_c_y_i,
  input  logic signed [COORD_BITS-1:0] vert_c_z_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [2*COORD_BITS+2:0]      sq_distance_o,
  output logic signed [COORD_BITS-1:0] near_x_o,
  output logic signed [COORD_BITS-1:0] near_y_o,
  output logic signed [COORD_BITS-1:0] near_z_o,
  output logic [2:0]                   region_o
);

  localparam int CW  = COORD_BITS;
  localparam int QWW = 3 + 6 * CW + 6 * (CW + 1) + 2 * (4 * CW + 7) + (4 * CW + 9);
  localparam int SQW = 2 * CW + 3;
  localparam int OWW = SQW + 3 * CW + 3;

  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] vta [3];
  logic signed [CW-1:0] vtb [3];
  logic signed [CW-1:0] vtc [3];
  logic                 front_ready;
  logic                 front_valid;
  logic [QWW-1:0]       front_data;
  logic                 mid_full, mid_empty;
  logic [QWW-1:0]       mid_data;
  logic                 back_ready;
  logic                 back_valid;
  logic [OWW-1:0]       back_data;
  logic                 out_full;
  logic [OWW-1:0]       out_data;

  assign pt  = '{point_x_i, point_y_i, point_z_i};
  assign vta = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign vtb = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign vtc = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};
  assign full = !front_ready;

  // Front part: classify each word.
  pctcp_front #(.CW(CW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_ready_o (front_ready),
    .pt_i       (pt),
    .vta_i      (vta),
    .vtb_i      (vtb),
    .vtc_i      (vtc),
    .out_valid_o(front_valid),
    .out_ready_i(!mid_full),
    .out_data_o (front_data)
  );

  // Queue that lets the two parts stall on their own.
  pctcp_fifo #(.W(QWW), .DEPTH(4)) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .data_i (front_data),
    .full_o (mid_full),
    .pop_i  (back_ready),
    .data_o (mid_data),
    .empty_o(mid_empty)
  );

  // Back part: fractions, rounding and distance.
  pctcp_back #(.CW(CW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!mid_empty),
    .in_ready_o (back_ready),
    .in_data_i  (mid_data),
    .out_valid_o(back_valid),
    .out_ready_i(!out_full),
    .out_data_o (back_data)
  );

  // Result queue seen by the consumer.
  pctcp_fifo #(.W(OWW), .DEPTH(2)) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_valid),
    .data_i (back_data),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_data),
    .empty_o(empty)
  );

  assign {sq_distance_o, near_x_o, near_y_o, near_z_o, region_o} = out_data;

endmodule

`default_nettype wire

/* rtl/pctcp_fifo.sv */
// Small register queue used between the front and back parts and at the output.
`default_nettype none

module pctcp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage for the queued words.
  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

/* rtl/pctcp_mul.sv */
// Two stage signed multiplier split into limb partial products.
`default_nettype none

module pctcp_mul import pctcp_pkg::*; #(
  parameter int AW = 51,
  parameter int BW = 51
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int L   = MUL_LIMB;
  localparam int NA  = (AW + L - 1) / L;
  localparam int NB  = (BW + L - 1) / L;
  localparam int PW  = AW + BW;
  localparam int PPW = 2 * L + 2;

  logic signed [NA*L-1:0] a_ext;
  logic signed [NB*L-1:0] b_ext;
  logic signed [L:0]      a_pc [NA];
  logic signed [L:0]      b_pc [NB];
  logic signed [PPW-1:0]  pp_q [NA*NB];
  logic signed [PW-1:0]   acc;

  assign a_ext = (NA * L)'(a_i);
  assign b_ext = (NB * L)'(b_i);

  // Lower limbs are unsigned, the top limb carries the sign.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) a_pc[i] = {a_ext[NA*L-1], a_ext[i*L +: L]};
      else a_pc[i] = {1'b0, a_ext[i*L +: L]};
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) b_pc[j] = {b_ext[NB*L-1], b_ext[j*L +: L]};
      else b_pc[j] = {1'b0, b_ext[j*L +: L]};
    end
  end

  // First stage: one register per partial product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i*NB+j] <= a_pc[i] * b_pc[j];
        end
      end
    end
  end

  // Second stage: shifted sum of the partial products.
  always_comb begin
    logic signed [PW-1:0] term;
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        term = PW'(pp_q[i*NB+j]);
        acc  = acc + (term <<< (L * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_o <= acc;
  end

endmodule

`default_nettype wire

/* rtl/pctcp_front.sv */
// Front part: dot products, barycentric terms and region classification.
`default_nettype none

module pctcp_front import pctcp_pkg::*; #(
  parameter int CW = 24,
  localparam int QWW = 3 + 6 * CW + 6 * (CW + 1) + 2 * (4 * CW + 7) + (4 * CW + 9)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [CW-1:0] pt_i [3],
  input  logic signed [CW-1:0] vta_i [3],
  input  logic signed [CW-1:0] vtb_i [3],
  input  logic signed [CW-1:0] vtc_i [3],
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [QWW-1:0]       out_data_o
);

  localparam int DW   = CW + 1;
  localparam int DOTW = 2 * CW + 3;
  localparam int MW   = 2 * DOTW;
  localparam int VW   = 2 * DOTW + 1;
  localparam int DENW = VW + 2;
  localparam int NST  = 7;

  logic [NST-1:0] vld_q;
  logic           en;

  logic signed [CW-1:0]     p_q [NST-1][3];
  logic signed [CW-1:0]     a_q [NST-1][3];
  logic signed [CW-1:0]     b_q [NST-1][3];
  logic signed [CW-1:0]     c_q [NST-1][3];
  logic signed [DW-1:0]     ab_q [NST-1][3];
  logic signed [DW-1:0]     ac_q [NST-1][3];
  logic signed [DW-1:0]     bc_q [NST-1][3];
  logic signed [DW-1:0]     ap_q [3];
  logic signed [DW-1:0]     bp_q [3];
  logic signed [DW-1:0]     cq_q [3];
  logic signed [2*DW-1:0]   pr_q [6][3];
  logic signed [DOTW-1:0]   d_q [NST-1][6];
  logic signed [MW-1:0]     m [6];
  logic signed [VW-1:0]     va_q, vb_q, vc_q;

  region_e                  rg_d, rg_q;
  logic signed [CW-1:0]     base_d [3];
  logic signed [CW-1:0]     ob_q [3];
  logic signed [CW-1:0]     op_q [3];
  logic signed [DW-1:0]     e1_d [3];
  logic signed [DW-1:0]     e2_d [3];
  logic signed [DW-1:0]     e1_q [3];
  logic signed [DW-1:0]     e2_q [3];
  logic signed [VW-1:0]     n1_d, n2_d, n1_q, n2_q;
  logic signed [DENW-1:0]   den_d, den_q;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  // Valid bits of the front pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Vertex products d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  pctcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul0 (
    .clk_i(clk_i), .en_i(en), .a_i(d_q[2][0]), .b_i(d_q[2][3]), .p_o(m[0])
  );
  pctcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul1 (
    .clk_i(clk_i), .en_i(en), .a_i(d_q[2][2]), .b_i(d_q[2][1]), .p_o(m[1])
  );
  pctcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul2 (
    .clk_i(clk_i), .en_i(en), .a_i(d_q[2][4]), .b_i(d_q[2][1]), .p_o(m[2])
  );
  pctcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul3 (
    .clk_i(clk_i), .en_i(en), .a_i(d_q[2][0]), .b_i(d_q[2][5]), .p_o(m[3])
  );
  pctcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul4 (
    .clk_i(clk_i), .en_i(en), .a_i(d_q[2][2]), .b_i(d_q[2][5]), .p_o(m[4])
  );
  pctcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul5 (
    .clk_i(clk_i), .en_i(en), .a_i(d_q[2][4]), .b_i(d_q[2][3]), .p_o(m[5])
  );

  // Datapath registers: differences, products, dot sums, vertex terms.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_q[0][k]  <= pt_i[k];
        a_q[0][k]  <= vta_i[k];
        b_q[0][k]  <= vtb_i[k];
        c_q[0][k]  <= vtc_i[k];
        ab_q[0][k] <= DW'(vtb_i[k]) - DW'(vta_i[k]);
        ac_q[0][k] <= DW'(vtc_i[k]) - DW'(vta_i[k]);
        bc_q[0][k] <= DW'(vtc_i[k]) - DW'(vtb_i[k]);
        ap_q[k]    <= DW'(pt_i[k]) - DW'(vta_i[k]);
        bp_q[k]    <= DW'(pt_i[k]) - DW'(vtb_i[k]);
        cq_q[k]    <= DW'(pt_i[k]) - DW'(vtc_i[k]);
      end
      for (int s = 1; s < NST - 1; s++) begin
        p_q[s]  <= p_q[s-1];
        a_q[s]  <= a_q[s-1];
        b_q[s]  <= b_q[s-1];
        c_q[s]  <= c_q[s-1];
        ab_q[s] <= ab_q[s-1];
        ac_q[s] <= ac_q[s-1];
        bc_q[s] <= bc_q[s-1];
      end
      for (int k = 0; k < 3; k++) begin
        pr_q[0][k] <= ab_q[0][k] * ap_q[k];
        pr_q[1][k] <= ac_q[0][k] * ap_q[k];
        pr_q[2][k] <= ab_q[0][k] * bp_q[k];
        pr_q[3][k] <= ac_q[0][k] * bp_q[k];
        pr_q[4][k] <= ab_q[0][k] * cq_q[k];
        pr_q[5][k] <= ac_q[0][k] * cq_q[k];
      end
      for (int j = 0; j < 6; j++) begin
        d_q[2][j] <= DOTW'(pr_q[j][0]) + DOTW'(pr_q[j][1]) + DOTW'(pr_q[j][2]);
      end
      for (int s = 3; s < NST - 1; s++) begin
        d_q[s] <= d_q[s-1];
      end
      vc_q <= VW'(m[0]) - VW'(m[1]);
      vb_q <= VW'(m[2]) - VW'(m[3]);
      va_q <= VW'(m[4]) - VW'(m[5]);
      rg_q  <= rg_d;
      op_q  <= p_q[5];
      ob_q  <= base_d;
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      n1_q  <= n1_d;
      n2_q  <= n2_d;
      den_q <= den_d;
    end
  end

  // Region tests in the published order. Without a usable fraction the
  // numerators are cleared and the denominator set to one, so the back
  // part yields the base vertex.
  always_comb begin
    logic signed [DOTW-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [DENW-1:0] dd;
    logic                   frac;
    d1 = d_q[5][0];
    d2 = d_q[5][1];
    d3 = d_q[5][2];
    d4 = d_q[5][3];
    d5 = d_q[5][4];
    d6 = d_q[5][5];
    rg_d   = REGION_VERT_A;
    base_d = a_q[5];
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = '0;
      e2_d[k] = '0;
    end
    n1_d = '0;
    n2_d = '0;
    dd   = '0;
    frac = 1'b0;
    if ((d1[DOTW-1] || d1 == '0) && (d2[DOTW-1] || d2 == '0)) begin
      rg_d = REGION_VERT_A;
    end else if (!d3[DOTW-1] && d4 <= d3) begin
      rg_d   = REGION_VERT_B;
      base_d = b_q[5];
    end else if ((vc_q[VW-1] || vc_q == '0) && !d1[DOTW-1] &&
                 (d3[DOTW-1] || d3 == '0)) begin
      rg_d = REGION_EDGE_AB;
      frac = 1'b1;
      e1_d = ab_q[5];
      n1_d = VW'(d1);
      dd   = DENW'(d1) - DENW'(d3);
    end else if (!d6[DOTW-1] && d5 <= d6) begin
      rg_d   = REGION_VERT_C;
      base_d = c_q[5];
    end else if ((vb_q[VW-1] || vb_q == '0) && !d2[DOTW-1] &&
                 (d6[DOTW-1] || d6 == '0)) begin
      rg_d = REGION_EDGE_AC;
      frac = 1'b1;
      e1_d = ac_q[5];
      n1_d = VW'(d2);
      dd   = DENW'(d2) - DENW'(d6);
    end else if ((va_q[VW-1] || va_q == '0) && d4 >= d3 && d5 >= d6) begin
      rg_d   = REGION_EDGE_BC;
      frac   = 1'b1;
      base_d = b_q[5];
      e1_d   = bc_q[5];
      n1_d   = VW'(d4) - VW'(d3);
      dd     = DENW'(n1_d) + DENW'(d5) - DENW'(d6);
    end else begin
      dd = DENW'(va_q) + DENW'(vb_q) + DENW'(vc_q);
      if (!dd[DENW-1] && dd != '0) begin
        rg_d = REGION_FACE;
        frac = 1'b1;
        e1_d = ab_q[5];
        e2_d = ac_q[5];
        n1_d = vb_q;
        n2_d = vc_q;
      end else begin
        rg_d = REGION_VERT_A;
      end
    end
    if (frac && !dd[DENW-1] && dd != '0) begin
      den_d = dd;
    end else begin
      n1_d  = '0;
      n2_d  = '0;
      den_d = DENW'(1);
    end
  end

  assign out_data_o = {rg_q, op_q[0], op_q[1], op_q[2], ob_q[0], ob_q[1], ob_q[2],
                       e1_q[0], e1_q[1], e1_q[2], e2_q[0], e2_q[1], e2_q[2],
                       n1_q, n2_q, den_q};

endmodule

`default_nettype wire

/* rtl/pctcp_back.sv */
// Back part: fraction numerators, rounded division, saturation and distance.
`default_nettype none

module pctcp_back #(
  parameter int CW = 24,
  localparam int QWW = 3 + 6 * CW + 6 * (CW + 1) + 2 * (4 * CW + 7) + (4 * CW + 9),
  localparam int OWW = (2 * CW + 3) + 3 * CW + 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [QWW-1:0] in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [OWW-1:0] out_data_o
);

  localparam int DW     = CW + 1;
  localparam int DOTW   = 2 * CW + 3;
  localparam int VW     = 2 * DOTW + 1;
  localparam int DENW   = VW + 2;
  localparam int NUMW   = VW + DW + 1;
  localparam int QB     = CW + 2;
  localparam int QW     = QB + 1;
  localparam int NDIV   = QW;
  localparam int RA     = NUMW + 1;
  localparam int RB     = DENW + QB;
  localparam int RW     = ((RA > RB) ? RA : RB) + 1;
  localparam int SQW    = 2 * CW + 3;
  localparam bit SQ_CLAMP = (SQW > 64);
  localparam int S_NRM  = 3;
  localparam int S_DIV0 = 4;
  localparam int S_NEAR = S_DIV0 + NDIV;
  localparam int S_SQ   = S_NEAR + 1;
  localparam int NST    = S_SQ + 2;

  logic [NST-1:0] vld_q;
  logic           en;

  logic [2:0]             in_rg;
  logic signed [CW-1:0]   in_p [3];
  logic signed [CW-1:0]   in_base [3];
  logic signed [DW-1:0]   in_e1 [3];
  logic signed [DW-1:0]   in_e2 [3];
  logic signed [VW-1:0]   in_n1, in_n2;
  logic signed [DENW-1:0] in_den;

  logic [2:0]             rg_q [NST];
  logic signed [CW-1:0]   p_q [NST][3];
  logic signed [CW-1:0]   base_q [NST][3];
  logic signed [DENW-1:0] den_q [S_NRM];
  logic signed [VW+DW-1:0] m1 [3];
  logic signed [VW+DW-1:0] m2 [3];
  logic signed [NUMW-1:0] num_q [3];
  logic [RW-1:0]          nrm_d [3];
  logic                   neg_q [NST][3];
  logic [RW-1:0]          dd_q [NST];
  logic [RW-1:0]          rem_q [NST][3];
  logic [QW-1:0]          quo_q [NST][3];
  logic [RW-1:0]          rem_d [NDIV][3];
  logic [QW-1:0]          quo_d [NDIV][3];
  logic signed [CW-1:0]   near_d [3];
  logic signed [CW-1:0]   near_q [3][3];
  logic [2*DW-1:0]        sq_d [3];
  logic [2*DW-1:0]        sq_q [3];
  logic [SQW-1:0]         tot_d, tot_q;

  assign {in_rg, in_p[0], in_p[1], in_p[2], in_base[0], in_base[1], in_base[2],
          in_e1[0], in_e1[1], in_e1[2], in_e2[0], in_e2[1], in_e2[2],
          in_n1, in_n2, in_den} = in_data_i;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  // Valid bits of the back pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Numerator products n1*e1 and n2*e2 per coordinate.
  for (genvar k = 0; k < 3; k++) begin : g_num
    pctcp_mul #(.AW(VW), .BW(DW)) u_mul1 (
      .clk_i(clk_i), .en_i(en), .a_i(in_n1), .b_i(in_e1[k]), .p_o(m1[k])
    );
    pctcp_mul #(.AW(VW), .BW(DW)) u_mul2 (
      .clk_i(clk_i), .en_i(en), .a_i(in_n2), .b_i(in_e2[k]), .p_o(m2[k])
    );
  end

  // Rounded dividend 2|num| + den, divisor 2 den.
  always_comb begin
    logic signed [RW-1:0] numx;
    logic [RW-1:0]        mag;
    for (int k = 0; k < 3; k++) begin
      numx     = RW'(num_q[k]);
      mag      = num_q[k][NUMW-1] ? -numx : numx;
      nrm_d[k] = (mag << 1) + RW'(den_q[S_NRM-1]);
    end
  end

  // Restoring division, one quotient bit per stage; the top bit flags overflow.
  always_comb begin
    logic [RW-1:0] shd;
    logic          ge;
    for (int s = 0; s < NDIV; s++) begin
      for (int k = 0; k < 3; k++) begin
        shd = dd_q[S_NRM+s] << (QB - s);
        ge  = (rem_q[S_NRM+s][k] >= shd);
        rem_d[s][k] = ge ? (rem_q[S_NRM+s][k] - shd) : rem_q[S_NRM+s][k];
        quo_d[s][k] = quo_q[S_NRM+s][k] | (QW'(ge) << (QB - s));
      end
    end
  end

  // Apply the signed fraction to the base vertex and saturate.
  always_comb begin
    logic signed [QW+1:0] qx, qs, sum;
    logic signed [CW-1:0] cmax, cmin;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    for (int k = 0; k < 3; k++) begin
      qx  = {2'b00, quo_q[S_NEAR-1][k]};
      qs  = neg_q[S_NEAR-1][k] ? -qx : qx;
      sum = (QW + 2)'(base_q[S_NEAR-1][k]) + qs;
      if (quo_q[S_NEAR-1][k][QB]) near_d[k] = neg_q[S_NEAR-1][k] ? cmin : cmax;
      else if (sum > (QW + 2)'(cmax)) near_d[k] = cmax;
      else if (sum < (QW + 2)'(cmin)) near_d[k] = cmin;
      else near_d[k] = sum[CW-1:0];
    end
  end

  // Squared differences and their sum, saturated to 64 bits when SQW exceeds 64.
  always_comb begin
    logic signed [DW-1:0]   df;
    logic signed [2*DW-1:0] pr;
    for (int k = 0; k < 3; k++) begin
      df       = DW'(p_q[S_NEAR][k]) - DW'(near_q[0][k]);
      pr       = df * df;
      sq_d[k]  = pr;
    end
    tot_d = SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
    if (SQ_CLAMP && (tot_d >> 64) != '0) tot_d = SQW'({64{1'b1}});
  end

  // Datapath registers of the back pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      rg_q[0]   <= in_rg;
      p_q[0]    <= in_p;
      base_q[0] <= in_base;
      den_q[0]  <= in_den;
      for (int s = 1; s < NST; s++) begin
        rg_q[s]   <= rg_q[s-1];
        p_q[s]    <= p_q[s-1];
        base_q[s] <= base_q[s-1];
      end
      for (int s = 1; s < S_NRM; s++) begin
        den_q[s] <= den_q[s-1];
      end
      for (int k = 0; k < 3; k++) begin
        num_q[k]            <= NUMW'(m1[k]) + NUMW'(m2[k]);
        neg_q[S_NRM][k]     <= num_q[k][NUMW-1];
        rem_q[S_NRM][k]     <= nrm_d[k];
        quo_q[S_NRM][k]     <= '0;
      end
      dd_q[S_NRM] <= RW'(den_q[S_NRM-1]) << 1;
      for (int s = S_DIV0; s < S_NEAR; s++) begin
        dd_q[s]  <= dd_q[s-1];
        neg_q[s] <= neg_q[s-1];
        rem_q[s] <= rem_d[s-S_DIV0];
        quo_q[s] <= quo_d[s-S_DIV0];
      end
      near_q[0] <= near_d;
      near_q[1] <= near_q[0];
      near_q[2] <= near_q[1];
      sq_q      <= sq_d;
      tot_q     <= tot_d;
    end
  end

  assign out_data_o = {tot_q, near_q[2][0], near_q[2][1], near_q[2][2], rg_q[NST-1]};

endmodule

`default_nettype wire
